>>> src/lzw_dictionary_trie_defines.svh
// assertion macros shared by the lzw dictionary trie checker
// no dependencies; include by bare file name
`ifndef LZW_DICTIONARY_TRIE_DEFINES_SVH
`define LZW_DICTIONARY_TRIE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LZWT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LZWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lzwt_pkg.sv
// types, constants and codes of the lzw dictionary trie
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package lzwt_pkg;

  localparam int CODE_BITS_LIMIT = 16;
  localparam int BASE_CODES      = 256;
  localparam int CODE_W          = CODE_BITS_LIMIT;
  localparam int TOTAL_CODES     = 1 << CODE_BITS_LIMIT;
  localparam int ADDED_CODES     = TOTAL_CODES - BASE_CODES;
  localparam int WALK_LIMIT      = 256;
  localparam int STEP_W          = $clog2(WALK_LIMIT + 1);
  localparam int BITS_W          = 5;
  localparam int BASE_W          = 9;
  localparam int SYM_W           = 8;
  localparam int MIN_CODE_BITS   = 9;

  // input actions
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } lzwt_action_t;

  // configuration register indexes
  localparam logic CFG_CODE_BITS   = 1'b0;
  localparam logic CFG_FIRST_ADDED = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [CODE_W-1:0] prefix_code;
    logic [SYM_W-1:0]  next_byte;
    logic [CODE_W-1:0] new_code;
  } lzwt_in_t;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] child_code;
  } lzwt_out_t;

  // trie link: defined flag and the linked code
  typedef struct packed {
    logic              defined;
    logic [CODE_W-1:0] code;
  } lzwt_link_t;

  // added-entry word: extending symbol and next-sibling link
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    lzwt_link_t       link;
  } lzwt_ent_t;

  // memory requests from the sequencer to the store
  typedef struct packed {
    logic              fc_re;
    logic [CODE_W-1:0] fc_raddr;
    logic              fc_we;
    logic [CODE_W-1:0] fc_waddr;
    lzwt_link_t        fc_wdata;
    logic              ent_re;
    logic [CODE_W-1:0] ent_raddr;
    logic              ent_link_we;
    logic              ent_sym_we;
    logic [CODE_W-1:0] ent_waddr;
    lzwt_link_t        ent_link_wdata;
    logic [SYM_W-1:0]  ent_sym_wdata;
  } lzwt_mem_req_t;

  // registered read data from the store
  typedef struct packed {
    lzwt_link_t       fc_q;
    lzwt_link_t       ent_link_q;
    logic [SYM_W-1:0] ent_sym_q;
  } lzwt_mem_rsp_t;

endpackage

>>> src/lzwt_store.sv
// first-child memory and added-entry memory (sibling link plus symbol)
// depends on lzwt_pkg; read data is registered and held between reads
`timescale 1ns / 1ps

module lzwt_store (
  input  logic                  clk,
  input  lzwt_pkg::lzwt_mem_req_t req,
  output lzwt_pkg::lzwt_mem_rsp_t rsp
);
  import lzwt_pkg::*;

  lzwt_link_t fc_mem  [TOTAL_CODES];
  lzwt_ent_t  ent_mem [ADDED_CODES];

  lzwt_link_t       fc_q_r;
  lzwt_link_t       ent_link_q_r;
  logic [SYM_W-1:0] ent_sym_q_r;

  // first-child port
  always_ff @(posedge clk) begin
    if (req.fc_we) begin
      fc_mem[req.fc_waddr] <= req.fc_wdata;
    end
    if (req.fc_re) begin
      fc_q_r <= fc_mem[req.fc_raddr];
    end
  end

  // added-entry port, link and symbol written separately
  always_ff @(posedge clk) begin
    if (req.ent_link_we) begin
      ent_mem[req.ent_waddr].link <= req.ent_link_wdata;
    end
    if (req.ent_sym_we) begin
      ent_mem[req.ent_waddr].sym <= req.ent_sym_wdata;
    end
    if (req.ent_re) begin
      ent_link_q_r <= ent_mem[req.ent_raddr].link;
      ent_sym_q_r  <= ent_mem[req.ent_raddr].sym;
    end
  end

  assign rsp.fc_q       = fc_q_r;
  assign rsp.ent_link_q = ent_link_q_r;
  assign rsp.ent_sym_q  = ent_sym_q_r;

endmodule

>>> src/lzw_dictionary_trie.sv
// LZW dictionary trie: one request at a time, one result per accepted request.
// After reset the block sweeps all 65536 first-child entries and the sibling
// links with in_ready low. A lookup reads the first-child entry of the prefix,
// then walks its child entries in the added-entry memory one read per cycle,
// at most 256 of them. An insert reads the first-child memory, then writes it
// and the added-entry memory; a no-op or an ignored insert only returns a
// result. A clear sweeps 2^code_bits_in_use first-child entries, one per cycle.
// A new request is taken while the previous result still waits in the output
// register.
// depends on lzwt_pkg and lzwt_store
`timescale 1ns / 1ps

module lzw_dictionary_trie (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lzwt_pkg::lzwt_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lzwt_pkg::lzwt_out_t   out_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [lzwt_pkg::BASE_W-1:0] cfg_wdata
);
  import lzwt_pkg::*;

  typedef enum logic [6:0] {
    S_INIT     = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_LOOK_FC  = 7'b0000100,
    S_LOOK_ENT = 7'b0001000,
    S_INS      = 7'b0010000,
    S_CLEAR    = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [BITS_W-1:0]   cfg_bits_r;
  logic [BASE_W-1:0]   cfg_base_r;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [CODE_W-1:0]   prefix_r, prefix_nxt;
  logic [CODE_W-1:0]   new_code_r, new_code_nxt;
  logic [CODE_W-1:0]   ins_idx_r, ins_idx_nxt;
  logic [CODE_W-1:0]   cur_code_r, cur_code_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic [CODE_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [CODE_W-1:0]   clr_last_r, clr_last_nxt;
  logic [CODE_W-1:0]   sib_lim_r, sib_lim_nxt;
  logic                res_found_r, res_found_nxt;
  logic [CODE_W-1:0]   res_code_r, res_code_nxt;
  logic                out_valid_r, out_valid_nxt;
  lzwt_out_t           out_data_r, out_data_nxt;

  logic [BITS_W-1:0]   bits_sat;
  logic [BASE_W-1:0]   base_sat;
  logic [CODE_W-1:0]   base_ext;
  logic [CODE_W:0]     total;
  lzwt_link_t          link_cur;
  logic                link_ok;
  logic [CODE_W-1:0]   link_idx;
  logic [CODE_W-1:0]   new_idx;
  logic                new_ok;
  logic                in_xfer;
  logic                slot_free;

  lzwt_mem_req_t       req;
  lzwt_mem_rsp_t       rsp;

  lzwt_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bits_r <= BITS_W'(CODE_BITS_LIMIT);
      cfg_base_r <= BASE_W'(BASE_CODES);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CODE_BITS:   cfg_bits_r <= cfg_wdata[BITS_W-1:0];
        CFG_FIRST_ADDED: cfg_base_r <= cfg_wdata;
        default:         cfg_bits_r <= cfg_bits_r;
      endcase
    end
  end

  // saturate the registers into their legal ranges
  always_comb begin
    bits_sat = cfg_bits_r;
    if (cfg_bits_r < BITS_W'(MIN_CODE_BITS)) bits_sat = BITS_W'(MIN_CODE_BITS);
    if (cfg_bits_r > BITS_W'(CODE_BITS_LIMIT)) bits_sat = BITS_W'(CODE_BITS_LIMIT);
    base_sat = cfg_base_r;
    if (cfg_base_r < BASE_W'(BASE_CODES))     base_sat = BASE_W'(BASE_CODES);
    if (cfg_base_r > BASE_W'(BASE_CODES + 1)) base_sat = BASE_W'(BASE_CODES + 1);
    base_ext = {{(CODE_W-BASE_W){1'b0}}, base_sat};
    total    = (CODE_W+1)'(1) << bits_sat;
  end

  // link check shared by the first-child and sibling steps of the walk
  always_comb begin
    link_cur = (state_r == S_LOOK_FC) ? rsp.fc_q : rsp.ent_link_q;
    link_idx = link_cur.code - base_ext;
    link_ok  = link_cur.defined && (link_cur.code >= base_ext) &&
               (link_idx < CODE_W'(ADDED_CODES));
    new_idx  = in_data.new_code - base_ext;
    new_ok   = (in_data.new_code >= base_ext) && (new_idx < CODE_W'(ADDED_CODES));
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    prefix_nxt    = prefix_r;
    new_code_nxt  = new_code_r;
    ins_idx_nxt   = ins_idx_r;
    cur_code_nxt  = cur_code_r;
    steps_nxt     = steps_r;
    clr_idx_nxt   = clr_idx_r;
    clr_last_nxt  = clr_last_r;
    sib_lim_nxt   = sib_lim_r;
    res_found_nxt = res_found_r;
    res_code_nxt  = res_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    req           = '0;

    unique case (state_r)
      S_INIT, S_CLEAR: begin
        // sweep one first-child entry per cycle, and one sibling link while below the limit
        req.fc_we          = 1'b1;
        req.fc_waddr       = clr_idx_r;
        req.fc_wdata       = '0;
        req.ent_link_we    = (clr_idx_r < sib_lim_r);
        req.ent_waddr      = clr_idx_r;
        req.ent_link_wdata = '0;
        clr_idx_nxt        = clr_idx_r + 1'b1;
        if (clr_idx_r == clr_last_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_RESULT;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          sym_nxt       = in_data.next_byte;
          prefix_nxt    = in_data.prefix_code;
          new_code_nxt  = in_data.new_code;
          ins_idx_nxt   = new_idx;
          steps_nxt     = '0;
          res_found_nxt = 1'b0;
          res_code_nxt  = '0;
          unique case (lzwt_action_t'(in_data.action))
            ACT_LOOKUP: begin
              req.fc_re    = 1'b1;
              req.fc_raddr = in_data.prefix_code;
              state_nxt    = S_LOOK_FC;
            end
            ACT_INSERT: begin
              req.fc_re    = new_ok;
              req.fc_raddr = in_data.prefix_code;
              state_nxt    = new_ok ? S_INS : S_RESULT;
            end
            ACT_CLEAR: begin
              clr_idx_nxt  = '0;
              clr_last_nxt = CODE_W'(total - 1'b1);
              sib_lim_nxt  = CODE_W'(total - (CODE_W+1)'(base_sat));
              state_nxt    = S_CLEAR;
            end
            ACT_NOP: begin
              state_nxt = S_RESULT;
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_LOOK_FC, S_LOOK_ENT: begin
        // compare the entry just read, stop at the walk limit, else follow the link in hand
        if ((state_r == S_LOOK_ENT) && (rsp.ent_sym_q == sym_r)) begin
          res_found_nxt = 1'b1;
          res_code_nxt  = cur_code_r;
          state_nxt     = S_RESULT;
        end else if ((state_r == S_LOOK_ENT) && (steps_r == STEP_W'(WALK_LIMIT))) begin
          state_nxt = S_RESULT;
        end else if (link_ok) begin
          req.ent_re    = 1'b1;
          req.ent_raddr = link_idx;
          cur_code_nxt  = link_cur.code;
          steps_nxt     = steps_r + 1'b1;
          state_nxt     = S_LOOK_ENT;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_INS: begin
        // new entry takes the old first child as its sibling
        req.fc_we          = 1'b1;
        req.fc_waddr       = prefix_r;
        req.fc_wdata       = '{defined: 1'b1, code: new_code_r};
        req.ent_link_we    = 1'b1;
        req.ent_sym_we     = 1'b1;
        req.ent_waddr      = ins_idx_r;
        req.ent_link_wdata = rsp.fc_q;
        req.ent_sym_wdata  = sym_r;
        state_nxt          = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: res_found_r, child_code: res_code_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_idx_r   <= '0;
      clr_last_r  <= CODE_W'(TOTAL_CODES - 1);
      sib_lim_r   <= CODE_W'(ADDED_CODES);
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_last_r  <= clr_last_nxt;
      sib_lim_r   <= sib_lim_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    prefix_r    <= prefix_nxt;
    new_code_r  <= new_code_nxt;
    ins_idx_r   <= ins_idx_nxt;
    cur_code_r  <= cur_code_nxt;
    res_found_r <= res_found_nxt;
    res_code_r  <= res_code_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/lzwt_checker.sv
// port-level checks of the lzw dictionary trie, bound to the top level
// depends on lzwt_pkg and lzw_dictionary_trie_defines.svh
`timescale 1ns / 1ps
`include "lzw_dictionary_trie_defines.svh"

module lzwt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input lzwt_pkg::lzwt_out_t         out_data
);
  import lzwt_pkg::*;

  // a stalled result holds
  `LZWT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_data), "result changed while stalled")

  // a miss carries code zero
  `LZWT_ASSERT_SAME(a_miss_zero, clk, rst_n, out_valid && !out_data.found,
                    out_data.child_code == '0, "miss with nonzero code")

  // a hit names an added code
  `LZWT_ASSERT_SAME(a_hit_added, clk, rst_n, out_valid && out_data.found,
                    out_data.child_code >= CODE_W'(BASE_CODES), "hit on a base code")

  // one request in work at a time
  `LZWT_ASSERT_NEXT(a_one_at_time, clk, rst_n, in_valid && in_ready, !in_ready,
                    "ready right after a transfer")

endmodule

bind lzw_dictionary_trie lzwt_checker u_lzwt_checker (.*);
